/* hdl/sofp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofp_pkg
// Shared types and constants of the start-of-frame length frame parser.
// ----------------------------------------------------------------------------
package sofp_pkg;

  localparam int unsigned MAX_PAYLOAD = 256;
  localparam int unsigned PAY_CNT_W   = $clog2(MAX_PAYLOAD + 1);

  localparam logic [7:0] SOF_BYTE = 8'hAA;

  localparam int unsigned SUB_W     = 2;
  localparam int unsigned RSV_BYTES = 2;
  localparam int unsigned LEN_BYTES = 4;
  localparam logic [SUB_W-1:0] RSV_LAST = SUB_W'(RSV_BYTES - 1);
  localparam logic [SUB_W-1:0] LEN_LAST = SUB_W'(LEN_BYTES - 1);

  localparam int unsigned REC_DEPTH = 2;
  localparam int unsigned REC_AW    = $clog2(REC_DEPTH);

  typedef enum logic [10:0] {
    PH_HUNT     = 11'b000_0000_0001,
    PH_VERSION  = 11'b000_0000_0010,
    PH_CMD_SET  = 11'b000_0000_0100,
    PH_CMD_ID   = 11'b000_0000_1000,
    PH_FLAGS    = 11'b000_0001_0000,
    PH_SENDER   = 11'b000_0010_0000,
    PH_RESERVED = 11'b000_0100_0000,
    PH_LENGTH   = 11'b000_1000_0000,
    PH_PAYLOAD  = 11'b001_0000_0000,
    PH_CRC      = 11'b010_0000_0000,
    PH_ERROR    = 11'b100_0000_0000
  } sofp_phase_e;

  typedef enum logic [2:0] {
    FLD_NONE,
    FLD_VERSION,
    FLD_CMD_SET,
    FLD_CMD_ID,
    FLD_FLAGS,
    FLD_SENDER,
    FLD_CRC_HI
  } sofp_field_e;

  typedef struct packed {
    logic [7:0] version;
    logic [7:0] cmd_set;
    logic [7:0] cmd_id;
    logic [7:0] flags;
    logic [7:0] sender;
    logic [7:0] crc_high;
  } sofp_rec_t;

  typedef struct packed {
    sofp_field_e       field;
    logic [7:0]        data;
    logic              emit_pay;
    logic              emit_done;
    logic [7:0]        index;
    logic [31:0]       length;
    logic [REC_AW-1:0] slot;
  } sofp_req_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  version;
    logic [7:0]  cmd_set;
    logic [7:0]  cmd_id;
    logic [7:0]  flag_bits;
    logic [7:0]  sender_id;
    logic [31:0] length_field;
    logic [15:0] crc_value;
    logic        last;
  } sofp_res_t;

endpackage

/* hdl/sof_length_frame_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_length_frame_parser_core
// Byte-serial frame deframer: start byte, header, big-endian length, payload
// and a captured CRC. Payload bytes come out with their index, and the last
// CRC byte produces a frame-complete request with the header fields.
//
//   Channel  Handshake                Payload
//   in       in_valid_i / in_stall_o  rx_byte_i
//   out      out_valid_o / out_stall_i out_kind_o, payload_byte_o,
//                                     payload_index_o, version_o, cmd_set_o,
//                                     cmd_id_o, flag_bits_o, sender_id_o,
//                                     length_field_o, crc_value_o, last_o
//
// One byte is accepted per cycle while in_stall_o is low. A result is registered
// in the record stage and again at the output: the header record is read from a
// two-entry RAM in the accept cycle and merged and written back in the next.
// Reset clears the sequencer and the valid flags; the RAM needs no clearing.
// An output stall holds the record stage only when it carries a result.
// ----------------------------------------------------------------------------
module sof_length_frame_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  payload_index_o,
  output logic [7:0]  version_o,
  output logic [7:0]  cmd_set_o,
  output logic [7:0]  cmd_id_o,
  output logic [7:0]  flag_bits_o,
  output logic [7:0]  sender_id_o,
  output logic [31:0] length_field_o,
  output logic [15:0] crc_value_o,
  output logic        last_o
);

  logic                accept;
  logic                hold;
  logic                take;
  logic                res_valid;
  sofp_pkg::sofp_req_t req;
  sofp_pkg::sofp_res_t res;
  sofp_pkg::sofp_res_t res_q;
  logic                out_valid_q, out_valid_d;

  assign in_stall_o = hold;
  assign accept     = in_valid_i & ~hold;
  assign take       = ~out_valid_q | ~out_stall_i;

  sofp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (rx_byte_i),
    .req_o    (req)
  );

  sofp_rec u_rec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req),
    .take_i      (take),
    .hold_o      (hold),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (~out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_kind_o      = res_q.kind;
  assign payload_byte_o  = res_q.payload_byte;
  assign payload_index_o = res_q.payload_index;
  assign version_o       = res_q.version;
  assign cmd_set_o       = res_q.cmd_set;
  assign cmd_id_o        = res_q.cmd_id;
  assign flag_bits_o     = res_q.flag_bits;
  assign sender_id_o     = res_q.sender_id;
  assign length_field_o  = res_q.length_field;
  assign crc_value_o     = res_q.crc_value;
  assign last_o          = res_q.last;

endmodule

/* hdl/sofp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofp_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module sofp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/sofp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofp_ctrl
// Frame sequencer: tracks the frame phase, counters and declared length and
// turns each accepted byte into a request for the header record stage.
// ----------------------------------------------------------------------------
module sofp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_i,
  output sofp_pkg::sofp_req_t req_o
);

  sofp_pkg::sofp_phase_e                 phase_q, phase_d;
  logic [sofp_pkg::SUB_W-1:0]            sub_q, sub_d;
  logic [sofp_pkg::PAY_CNT_W-1:0]        cnt_q, cnt_d;
  logic [sofp_pkg::PAY_CNT_W-1:0]        cnt_inc;
  logic [31:0]                           len_q, len_d;
  logic [31:0]                           len_shift;
  logic [sofp_pkg::REC_AW-1:0]           slot_q, slot_d;

  assign cnt_inc   = cnt_q + sofp_pkg::PAY_CNT_W'(1);
  assign len_shift = {len_q[23:0], byte_i};

  always_comb begin
    phase_d = phase_q;
    sub_d   = sub_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    slot_d  = slot_q;

    req_o.field     = sofp_pkg::FLD_NONE;
    req_o.data      = byte_i;
    req_o.emit_pay  = 1'b0;
    req_o.emit_done = 1'b0;
    req_o.index     = 8'(cnt_q);
    req_o.length    = len_q;
    req_o.slot      = slot_q;

    case (phase_q)
      sofp_pkg::PH_HUNT: begin
        phase_d = (byte_i == sofp_pkg::SOF_BYTE) ? sofp_pkg::PH_VERSION
                                                 : sofp_pkg::PH_ERROR;
      end
      sofp_pkg::PH_VERSION: begin
        req_o.field = sofp_pkg::FLD_VERSION;
        phase_d     = sofp_pkg::PH_CMD_SET;
      end
      sofp_pkg::PH_CMD_SET: begin
        req_o.field = sofp_pkg::FLD_CMD_SET;
        phase_d     = sofp_pkg::PH_CMD_ID;
      end
      sofp_pkg::PH_CMD_ID: begin
        req_o.field = sofp_pkg::FLD_CMD_ID;
        phase_d     = sofp_pkg::PH_FLAGS;
      end
      sofp_pkg::PH_FLAGS: begin
        req_o.field = sofp_pkg::FLD_FLAGS;
        phase_d     = sofp_pkg::PH_SENDER;
      end
      sofp_pkg::PH_SENDER: begin
        req_o.field = sofp_pkg::FLD_SENDER;
        phase_d     = sofp_pkg::PH_RESERVED;
        sub_d       = '0;
      end
      sofp_pkg::PH_RESERVED: begin
        if (sub_q == sofp_pkg::RSV_LAST) begin
          sub_d   = '0;
          len_d   = '0;
          phase_d = sofp_pkg::PH_LENGTH;
        end else begin
          sub_d = sub_q + sofp_pkg::SUB_W'(1);
        end
      end
      sofp_pkg::PH_LENGTH: begin
        len_d = len_shift;
        if (sub_q == sofp_pkg::LEN_LAST) begin
          sub_d   = '0;
          cnt_d   = '0;
          phase_d = (len_shift == 32'd0) ? sofp_pkg::PH_CRC : sofp_pkg::PH_PAYLOAD;
        end else begin
          sub_d = sub_q + sofp_pkg::SUB_W'(1);
        end
      end
      sofp_pkg::PH_PAYLOAD: begin
        req_o.emit_pay = 1'b1;
        cnt_d          = cnt_inc;
        if ((32'(cnt_inc) == len_q) ||
            (cnt_inc >= sofp_pkg::PAY_CNT_W'(sofp_pkg::MAX_PAYLOAD))) begin
          sub_d   = '0;
          phase_d = sofp_pkg::PH_CRC;
        end
      end
      sofp_pkg::PH_CRC: begin
        if (sub_q == '0) begin
          req_o.field = sofp_pkg::FLD_CRC_HI;
          sub_d       = sofp_pkg::SUB_W'(1);
        end else begin
          req_o.emit_done = 1'b1;
          phase_d         = sofp_pkg::PH_HUNT;
          sub_d           = '0;
          cnt_d           = '0;
          len_d           = '0;
          slot_d          = slot_q + sofp_pkg::REC_AW'(1);
        end
      end
      sofp_pkg::PH_ERROR: begin
        phase_d = sofp_pkg::PH_HUNT;
      end
      default: begin
        phase_d = sofp_pkg::PH_HUNT;
        sub_d   = '0;
        cnt_d   = '0;
        len_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sofp_pkg::PH_HUNT;
      sub_q   <= '0;
      cnt_q   <= '0;
      len_q   <= '0;
      slot_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      sub_q   <= sub_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      slot_q  <= slot_d;
    end
  end

endmodule

/* hdl/sofp_rec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofp_rec
// Header record stage: reads the frame's header record from RAM, merges the
// captured byte, writes it back and forms the result. A write to the same
// entry in the cycle of the read is forwarded from a holding register.
// ----------------------------------------------------------------------------
module sofp_rec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  sofp_pkg::sofp_req_t req_i,
  input  logic                take_i,
  output logic                hold_o,
  output logic                res_valid_o,
  output sofp_pkg::sofp_res_t res_o
);

  logic                b_valid_q, b_valid_d;
  logic                fwd_q, fwd_d;
  sofp_pkg::sofp_req_t b_req_q;
  sofp_pkg::sofp_rec_t wr_q;
  sofp_pkg::sofp_rec_t rd_data;
  sofp_pkg::sofp_rec_t base;
  sofp_pkg::sofp_rec_t new_rec;
  logic                b_emit;
  logic                b_fire;
  logic                b_write;

  assign b_emit  = b_req_q.emit_pay | b_req_q.emit_done;
  assign b_fire  = b_valid_q & (~b_emit | take_i);
  assign b_write = b_fire & (b_req_q.field != sofp_pkg::FLD_NONE);
  assign hold_o  = b_valid_q & ~b_fire;

  assign base = fwd_q ? wr_q : rd_data;

  always_comb begin
    new_rec = base;
    case (b_req_q.field)
      sofp_pkg::FLD_VERSION: new_rec.version  = b_req_q.data;
      sofp_pkg::FLD_CMD_SET: new_rec.cmd_set  = b_req_q.data;
      sofp_pkg::FLD_CMD_ID:  new_rec.cmd_id   = b_req_q.data;
      sofp_pkg::FLD_FLAGS:   new_rec.flags    = b_req_q.data;
      sofp_pkg::FLD_SENDER:  new_rec.sender   = b_req_q.data;
      sofp_pkg::FLD_CRC_HI:  new_rec.crc_high = b_req_q.data;
      default:               new_rec = base;
    endcase
  end

  always_comb begin
    res_o = '0;
    if (b_req_q.emit_done) begin
      res_o.kind         = 1'b1;
      res_o.version      = base.version;
      res_o.cmd_set      = base.cmd_set;
      res_o.cmd_id       = base.cmd_id;
      res_o.flag_bits    = base.flags;
      res_o.sender_id    = base.sender;
      res_o.length_field = b_req_q.length;
      res_o.crc_value    = {base.crc_high, b_req_q.data};
      res_o.last         = 1'b1;
    end else begin
      res_o.payload_byte  = b_req_q.data;
      res_o.payload_index = b_req_q.index;
    end
  end

  assign res_valid_o = b_fire & b_emit;

  always_comb begin
    b_valid_d = b_valid_q;
    fwd_d     = fwd_q;
    if (accept_i) begin
      b_valid_d = 1'b1;
      fwd_d     = b_write & (b_req_q.slot == req_i.slot);
    end else if (b_fire) begin
      b_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
      fwd_q     <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      b_req_q <= req_i;
    end
    if (b_write) begin
      wr_q <= new_rec;
    end
  end

  sofp_ram #(
    .WIDTH ($bits(sofp_pkg::sofp_rec_t)),
    .DEPTH (sofp_pkg::REC_DEPTH)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (b_write),
    .waddr_i (b_req_q.slot),
    .wdata_i (new_rec),
    .re_i    (accept_i),
    .raddr_i (req_i.slot),
    .rdata_o (rd_data)
  );

endmodule
